// ===== rtl/mrsr_pkg.sv =====
// ----------------------------------------------------------------------------
// mrsr_pkg
// Shared types and constants for the marked reverse string recogniser.
// ----------------------------------------------------------------------------
package mrsr_pkg;

  localparam int STACK_DEPTH = 64;
  localparam int SYM_W       = 8;
  localparam int SP_W        = $clog2(STACK_DEPTH + 1);

  localparam logic [SYM_W-1:0] MARKER_RESET = 8'd99;

  // Error kinds reported with the verdict
  typedef enum logic [2:0] {
    ERR_NONE      = 3'd0,
    ERR_NO_MARKER = 3'd1,
    ERR_MISMATCH  = 3'd2,
    ERR_LENGTH    = 3'd3,
    ERR_OVERFLOW  = 3'd4
  } err_t;

  // Shift command broadcast to every stack cell
  typedef struct packed {
    logic push;
    logic pop;
  } stack_op_t;

endpackage

// ===== rtl/mrsr_cell.sv =====
// ----------------------------------------------------------------------------
// mrsr_cell
// One stack entry. Push loads from the neighbour nearer the top, pop loads
// from the neighbour further down.
// ----------------------------------------------------------------------------
module mrsr_cell
  import mrsr_pkg::*;
(
  input  logic             clk,
  input  stack_op_t        op,
  input  logic [SYM_W-1:0] above_sym,
  input  logic [SYM_W-1:0] below_sym,
  output logic [SYM_W-1:0] cell_sym
);

  logic [SYM_W-1:0] sym_r;
  logic [SYM_W-1:0] sym_nxt;

  // shift up or down the chain
  always_comb begin
    sym_nxt = sym_r;
    if (op.push) begin
      sym_nxt = above_sym;
    end else if (op.pop) begin
      sym_nxt = below_sym;
    end
  end

  always_ff @(posedge clk) begin
    sym_r <= sym_nxt;
  end

  assign cell_sym = sym_r;

endmodule

// ===== rtl/mrsr_ctrl.sv =====
// ----------------------------------------------------------------------------
// mrsr_ctrl
// Stack pointer, phase and first-error tracking, marker register and the
// registered verdict word.
// ----------------------------------------------------------------------------
module mrsr_ctrl
  import mrsr_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             cfg_wr_en,
  input  logic [SYM_W-1:0] cfg_wr_data,
  input  logic             in_tvalid,
  output logic             in_tready,
  input  logic [SYM_W-1:0] in_sym,
  input  logic             in_tlast,
  output logic             out_tvalid,
  input  logic             out_tready,
  output logic             out_verdict,
  output err_t             out_err,
  input  logic [SYM_W-1:0] top_sym,
  output stack_op_t        op
);

  typedef enum logic [1:0] {
    PH_PUSH  = 2'd0,
    PH_MATCH = 2'd1
  } phase_t;

  phase_t           phase_r, phase_nxt;
  logic [SP_W-1:0]  sp_r, sp_nxt;
  err_t             err_r, err_nxt;
  logic [SYM_W-1:0] marker_r;
  logic             out_valid_r, out_valid_nxt;
  logic             verdict_r, verdict_nxt;
  err_t             err_out_r, err_out_nxt;
  logic             accept;
  err_t             err_step;
  phase_t           phase_step;
  logic [SP_W-1:0]  sp_step;

  // output register frees itself when the word is taken
  assign in_tready = !out_valid_r || out_tready;
  assign accept    = in_tvalid && in_tready;

  // per-symbol step
  always_comb begin
    err_step   = err_r;
    phase_step = phase_r;
    sp_step    = sp_r;
    op         = '0;
    if (accept && err_r == ERR_NONE) begin
      unique case (phase_r)
        PH_PUSH: begin
          if (in_sym == marker_r) begin
            phase_step = PH_MATCH;
          end else if (sp_r == SP_W'(STACK_DEPTH)) begin
            err_step = ERR_OVERFLOW;
          end else begin
            op.push = 1'b1;
            sp_step = sp_r + 1'b1;
          end
        end
        PH_MATCH: begin
          if (sp_r == '0) begin
            err_step = ERR_LENGTH;
          end else begin
            op.pop  = 1'b1;
            sp_step = sp_r - 1'b1;
            if (top_sym != in_sym) begin
              err_step = ERR_MISMATCH;
            end
          end
        end
        default: ;
      endcase
    end
  end

  // end of string: final checks, verdict and clear
  always_comb begin
    phase_nxt     = phase_step;
    sp_nxt        = sp_step;
    err_nxt       = err_step;
    out_valid_nxt = out_valid_r && !out_tready;
    verdict_nxt   = verdict_r;
    err_out_nxt   = err_out_r;
    if (accept && in_tlast) begin
      err_out_nxt = err_step;
      if (err_step == ERR_NONE) begin
        if (phase_step == PH_PUSH) begin
          err_out_nxt = ERR_NO_MARKER;
        end else if (sp_step != '0) begin
          err_out_nxt = ERR_LENGTH;
        end
      end
      verdict_nxt   = (err_out_nxt == ERR_NONE);
      out_valid_nxt = 1'b1;
      phase_nxt     = PH_PUSH;
      sp_nxt        = '0;
      err_nxt       = ERR_NONE;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_PUSH;
      sp_r        <= '0;
      err_r       <= ERR_NONE;
      marker_r    <= MARKER_RESET;
      out_valid_r <= 1'b0;
    end else begin
      phase_r     <= phase_nxt;
      sp_r        <= sp_nxt;
      err_r       <= err_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_wr_en) begin
        marker_r <= cfg_wr_data;
      end
    end
    verdict_r <= verdict_nxt;
    err_out_r <= err_out_nxt;
  end

  assign out_tvalid  = out_valid_r;
  assign out_verdict = verdict_r;
  assign out_err     = err_out_r;

endmodule

// ===== rtl/marked_reverse_string_recognizer_unit.sv =====
// ----------------------------------------------------------------------------
// marked_reverse_string_recognizer_unit
// Recognises strings of the form w, marker, reverse(w) with a shift stack.
// ----------------------------------------------------------------------------
// Takes one symbol word per cycle, back to back, and gives one verdict word
// the cycle after the word flagged by in_tlast. The stack is a chain of
// STACK_DEPTH cells that shift down on a push and up on a pop, so the top
// entry is always in the first cell, where it is compared with the incoming
// symbol. A verdict word is held in the output register; the input stalls
// only while that word is held and out_tready is low, so with the result
// side ready the input never stalls. Only the first error in a string is
// reported; the stack is emptied after every verdict. The marker symbol
// (reset 99) is written through cfg_wr_en / cfg_wr_data; the user must do so
// only while the unit is idle, as the unit itself does not enforce this.
module marked_reverse_string_recognizer_unit
  import mrsr_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       cfg_wr_en,
  input  logic [7:0] cfg_wr_data,  // marker_symbol
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [7:0] in_tdata,     // [7:0] symbol
  input  logic       in_tlast,     // last_symbol
  output logic       out_tvalid,
  input  logic       out_tready,
  output logic [7:0] out_tdata     // [0] verdict, [3:1] error_kind, [7:4] zero
);

  stack_op_t        op;
  logic [SYM_W-1:0] cell_sym [STACK_DEPTH];
  logic             verdict;
  err_t             err;

  // control and verdict register
  mrsr_ctrl u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_sym      (in_tdata),
    .in_tlast    (in_tlast),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_verdict (verdict),
    .out_err     (err),
    .top_sym     (cell_sym[0]),
    .op          (op)
  );

  // stack chain, cell 0 is the top
  for (genvar i = 0; i < STACK_DEPTH; i++) begin : g_cell
    logic [SYM_W-1:0] above;
    logic [SYM_W-1:0] below;
    if (i == 0) begin : g_first
      assign above = in_tdata;
    end else begin : g_mid
      assign above = cell_sym[i-1];
    end
    if (i == STACK_DEPTH - 1) begin : g_last
      assign below = '0;
    end else begin : g_inner
      assign below = cell_sym[i+1];
    end
    mrsr_cell u_cell (
      .clk       (clk),
      .op        (op),
      .above_sym (above),
      .below_sym (below),
      .cell_sym  (cell_sym[i])
    );
  end

  assign out_tdata = {4'b0000, err, verdict};

endmodule
